@@ rtl/core/lbd_pkg.sv @@
// ----------------------------------------------------------------------------
// lbd_pkg: shared types and constants for the Legendre basis block
// Number formats, microcode word layout, microprogram ROM and the recurrence
// coefficient table.
// ----------------------------------------------------------------------------
package lbd_pkg;

	// field widths
	localparam int X_W   = 17;
	localparam int IDX_W = 5;
	localparam int CNT_W = 6;
	localparam int PV_W  = 17;
	localparam int FD_W  = 25;
	localparam int SD_W  = 33;

	// configuration port
	localparam int ADDR_W = 2;
	localparam int DATA_W = 32;
	localparam logic [ADDR_W-1:0] REG_NUM_ORDERS = 2'd0;
	localparam logic [CNT_W-1:0]  NUM_ORDERS_RST = 6'd32;

	localparam int RESULT_LIMIT = 32;

	// datapath: Q.24 values, 18 x 25 multiplier walked over two halves
	localparam int NUM_LANES = 3;
	localparam int LANE_P    = 0;
	localparam int LANE_D    = 1;
	localparam int LANE_S    = 2;
	localparam int VAL_W     = 48;
	localparam int HALF_W    = 24;
	localparam int MUL_A_W   = 18;
	localparam int MUL_B_W   = HALF_W + 1;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int ACC_W     = PROD_W + HALF_W;
	localparam int COEF_W1   = 17;
	localparam int COEF_W2   = 16;

	localparam int SH_X   = 15;   // Q.15 x Q.24 back to Q.24
	localparam int SH_C   = 16;   // Q.16 x Q.24 back to Q.24
	localparam int SH_OUT = 9;    // Q.24 to Q.15
	localparam int SH_P1  = 9;    // x (Q.15) into Q.24

	localparam logic signed [ACC_W-1:0] RND_X = ACC_W'(1) << (SH_X - 1);
	localparam logic signed [ACC_W-1:0] RND_C = ACC_W'(1) << (SH_C - 1);
	localparam logic signed [VAL_W-1:0] RND_O = VAL_W'(1) << (SH_OUT - 1);
	localparam logic signed [VAL_W-1:0] ONE_Q24 = VAL_W'(1) << 24;

	localparam logic signed [X_W-1:0] X_MIN = -17'sd32768;
	localparam logic signed [X_W-1:0] X_MAX = 17'sd32768;

	localparam logic signed [VAL_W-1:0] PV_LIM = 48'sd32768;
	localparam logic signed [VAL_W-1:0] FD_LIM = 48'sd16252928;
	localparam logic signed [VAL_W-1:0] SD_LIM = 48'sd4022599680;

	// microprogram steps
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] STEP_IDLE = 4'd0;
	localparam logic [PC_W-1:0] STEP_E0   = 4'd1;
	localparam logic [PC_W-1:0] STEP_E1   = 4'd2;
	localparam logic [PC_W-1:0] STEP_XLO  = 4'd3;
	localparam logic [PC_W-1:0] STEP_XHI  = 4'd4;
	localparam logic [PC_W-1:0] STEP_TMP  = 4'd5;
	localparam logic [PC_W-1:0] STEP_C1LO = 4'd6;
	localparam logic [PC_W-1:0] STEP_C1HI = 4'd7;
	localparam logic [PC_W-1:0] STEP_C2LO = 4'd8;
	localparam logic [PC_W-1:0] STEP_C2HI = 4'd9;
	localparam logic [PC_W-1:0] STEP_SHIFT = 4'd10;
	localparam logic [PC_W-1:0] STEP_EMIT = 4'd11;

	typedef enum logic [1:0] {OPA_X, OPA_C1, OPA_C2} opa_t;
	typedef enum logic [1:0] {OPB_V1, OPB_T, OPB_V2} opb_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_t;
	typedef enum logic [1:0] {EMIT_NONE, EMIT_V2, EMIT_V1} emit_t;
	typedef enum logic [1:0] {JMP_NEXT, JMP_WAIT, JMP_LAST} jmp_t;

	typedef struct packed {
		opa_t            opa;
		opb_t            opb;
		logic            hi;
		acc_t            acc;
		logic            wr_t;
		logic            wr_v;
		logic            init;
		logic            inc_n;
		emit_t           emit;
		jmp_t            jmp;
		logic [PC_W-1:0] target;
	} uword_t;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{opa: OPA_X, opb: OPB_V1, hi: 1'b0, acc: ACC_HOLD, wr_t: 1'b0,
			wr_v: 1'b0, init: 1'b0, inc_n: 1'b0, emit: EMIT_NONE, jmp: JMP_NEXT,
			target: STEP_IDLE};
		unique case (pc) inside
			STEP_IDLE: begin
				w.init = 1'b1;
				w.jmp  = JMP_WAIT;
			end
			STEP_E0: begin
				w.emit  = EMIT_V2;
				w.inc_n = 1'b1;
			end
			STEP_E1, STEP_EMIT: begin
				w.emit   = EMIT_V1;
				w.inc_n  = 1'b1;
				w.jmp    = JMP_LAST;
				w.target = STEP_XLO;
			end
			STEP_XLO: begin
				w.acc = ACC_LOAD;
			end
			STEP_XHI: begin
				w.hi  = 1'b1;
				w.acc = ACC_ADD;
			end
			STEP_TMP: begin
				w.wr_t = 1'b1;
			end
			STEP_C1LO: begin
				w.opa = OPA_C1;
				w.opb = OPB_T;
				w.acc = ACC_LOAD;
			end
			STEP_C1HI: begin
				w.opa = OPA_C1;
				w.opb = OPB_T;
				w.hi  = 1'b1;
				w.acc = ACC_ADD;
			end
			STEP_C2LO: begin
				w.opa = OPA_C2;
				w.opb = OPB_V2;
				w.acc = ACC_SUB;
			end
			STEP_C2HI: begin
				w.opa = OPA_C2;
				w.opb = OPB_V2;
				w.hi  = 1'b1;
				w.acc = ACC_SUB;
			end
			STEP_SHIFT: begin
				w.wr_v = 1'b1;
			end
			default: begin
				w.jmp    = JMP_LAST;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	// (2n-1)/n in Q.16, rounded half up
	function automatic logic [COEF_W1-1:0] coef_c1(input logic [IDX_W-1:0] n);
		logic [COEF_W1-1:0] c;
		unique case (n)
			5'd2:  c = 17'd98304;
			5'd3:  c = 17'd109227;
			5'd4:  c = 17'd114688;
			5'd5:  c = 17'd117965;
			5'd6:  c = 17'd120149;
			5'd7:  c = 17'd121710;
			5'd8:  c = 17'd122880;
			5'd9:  c = 17'd123790;
			5'd10: c = 17'd124518;
			5'd11: c = 17'd125114;
			5'd12: c = 17'd125611;
			5'd13: c = 17'd126031;
			5'd14: c = 17'd126391;
			5'd15: c = 17'd126703;
			5'd16: c = 17'd126976;
			5'd17: c = 17'd127217;
			5'd18: c = 17'd127431;
			5'd19: c = 17'd127623;
			5'd20: c = 17'd127795;
			5'd21: c = 17'd127951;
			5'd22: c = 17'd128093;
			5'd23: c = 17'd128223;
			5'd24: c = 17'd128341;
			5'd25: c = 17'd128451;
			5'd26: c = 17'd128551;
			5'd27: c = 17'd128645;
			5'd28: c = 17'd128731;
			5'd29: c = 17'd128812;
			5'd30: c = 17'd128887;
			5'd31: c = 17'd128958;
			default: c = '0;
		endcase
		return c;
	endfunction

	// (n-1)/n in Q.16, rounded half up
	function automatic logic [COEF_W2-1:0] coef_c2(input logic [IDX_W-1:0] n);
		logic [COEF_W2-1:0] c;
		unique case (n)
			5'd2:  c = 16'd32768;
			5'd3:  c = 16'd43691;
			5'd4:  c = 16'd49152;
			5'd5:  c = 16'd52429;
			5'd6:  c = 16'd54613;
			5'd7:  c = 16'd56174;
			5'd8:  c = 16'd57344;
			5'd9:  c = 16'd58254;
			5'd10: c = 16'd58982;
			5'd11: c = 16'd59578;
			5'd12: c = 16'd60075;
			5'd13: c = 16'd60495;
			5'd14: c = 16'd60855;
			5'd15: c = 16'd61167;
			5'd16: c = 16'd61440;
			5'd17: c = 16'd61681;
			5'd18: c = 16'd61895;
			5'd19: c = 16'd62087;
			5'd20: c = 16'd62259;
			5'd21: c = 16'd62415;
			5'd22: c = 16'd62557;
			5'd23: c = 16'd62687;
			5'd24: c = 16'd62805;
			5'd25: c = 16'd62915;
			5'd26: c = 16'd63015;
			5'd27: c = 16'd63109;
			5'd28: c = 16'd63195;
			5'd29: c = 16'd63276;
			5'd30: c = 16'd63351;
			5'd31: c = 16'd63422;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat(input logic signed [VAL_W-1:0] v,
			input logic signed [VAL_W-1:0] lim);
		logic signed [VAL_W-1:0] r;
		if (v > lim) begin
			r = lim;
		end else if (v < -lim) begin
			r = -lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/legendre_basis_with_derivatives.sv @@
// ----------------------------------------------------------------------------
// legendre_basis_with_derivatives: Legendre P_n, P_n', P_n'' per position
// Microcoded three-lane datapath running the three-term recurrence in Q.24.
// ----------------------------------------------------------------------------
// One position word x_pos (Q.15, clamped to -1.0..+1.0) yields num_orders result
// words, orders 0 upward, each with P_n(x), P_n'(x) and P_n''(x) in Q.15,
// saturated to the field ranges, and last_order set on the final one.
// num_orders below 2 acts as 2; above MAX_ORDERS (or 32) it is capped there.
// Timing: a new position is taken in the cycle after the last result word
// has been loaded into the output register. The microprogram gives each
// order after the first two nine steps, as every lane has one 18 x 25
// multiplier that covers each 48-bit operand in two halves (x*v, c1*t,
// c2*v), plus a rounding step, a shift step and an output step. Write
// num_orders only while the block is idle.
// ----------------------------------------------------------------------------
module legendre_basis_with_derivatives #(
	parameter int MAX_ORDERS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lbd_pkg::ADDR_W-1:0]       paddr,
	input  logic [lbd_pkg::DATA_W-1:0]       pwdata,
	output logic [lbd_pkg::DATA_W-1:0]       prdata,
	output logic                             pready,
	// position word
	input  logic                             pos_valid,
	output logic                             pos_stall,
	input  logic signed [lbd_pkg::X_W-1:0]   x_pos,
	// result word
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic [lbd_pkg::IDX_W-1:0]        order_index,
	output logic signed [lbd_pkg::PV_W-1:0]  poly_value,
	output logic signed [lbd_pkg::FD_W-1:0]  first_deriv,
	output logic signed [lbd_pkg::SD_W-1:0]  second_deriv,
	output logic                             last_order
);

	// effective order cap
	localparam int LIMIT = (MAX_ORDERS < lbd_pkg::RESULT_LIMIT) ? MAX_ORDERS
		: lbd_pkg::RESULT_LIMIT;
	localparam logic [lbd_pkg::IDX_W-1:0] LAST_MAX = lbd_pkg::IDX_W'(LIMIT - 1);
	localparam int NL = lbd_pkg::NUM_LANES;
	localparam int VW = lbd_pkg::VAL_W;
	localparam int AW = lbd_pkg::ACC_W;

	// control state
	logic [lbd_pkg::PC_W-1:0]  pc_q;
	logic [lbd_pkg::IDX_W-1:0] n_q;
	logic [lbd_pkg::IDX_W-1:0] last_q;
	logic [lbd_pkg::CNT_W-1:0] num_orders_q;
	logic                      res_valid_q;

	// datapath registers, one entry per lane (P, P', P'')
	logic signed [lbd_pkg::X_W-1:0] x_q;
	logic signed [VW-1:0] v1_q [NL];   // order n-1
	logic signed [VW-1:0] v2_q [NL];   // order n-2
	logic signed [VW-1:0] t_q  [NL];   // x*v1 + addend, rounded
	logic signed [AW-1:0] acc_q [NL];

	// output register
	logic [lbd_pkg::IDX_W-1:0]       order_q;
	logic signed [lbd_pkg::PV_W-1:0] pv_q;
	logic signed [lbd_pkg::FD_W-1:0] fd_q;
	logic signed [lbd_pkg::SD_W-1:0] sd_q;
	logic                            last_out_q;

	lbd_pkg::uword_t uw;
	logic pos_acc, emit_ok, emit_fire, hold, advance, is_last;
	logic [lbd_pkg::PC_W-1:0]  pc_next;
	logic [lbd_pkg::IDX_W-1:0] last_d;
	logic signed [lbd_pkg::X_W-1:0] x_cl;
	logic signed [lbd_pkg::MUL_A_W-1:0] a_op;
	logic signed [lbd_pkg::MUL_B_W-1:0] b_op  [NL];
	logic signed [lbd_pkg::PROD_W-1:0]  prod  [NL];
	logic signed [AW-1:0] prod_ext [NL];
	logic signed [AW-1:0] sum_x    [NL];
	logic signed [AW-1:0] sum_c    [NL];
	logic signed [VW-1:0] addend   [NL];
	logic signed [VW-1:0] t_new    [NL];
	logic signed [VW-1:0] v_new    [NL];
	logic signed [VW-1:0] src_b    [NL];
	logic signed [VW-1:0] src_o    [NL];
	logic signed [VW-1:0] rnd_o    [NL];

	assign uw = lbd_pkg::ucode(pc_q);

	// handshakes; only the idle step takes a position
	assign pos_stall = (pc_q != lbd_pkg::STEP_IDLE);
	assign pos_acc   = pos_valid && !pos_stall;
	assign emit_ok   = !res_valid_q || !res_stall;
	assign emit_fire = (uw.emit != lbd_pkg::EMIT_NONE) && emit_ok;
	assign hold      = ((uw.emit != lbd_pkg::EMIT_NONE) && !emit_ok)
		|| ((uw.jmp == lbd_pkg::JMP_WAIT) && !pos_valid);
	assign advance   = !hold;
	assign is_last   = (n_q == last_q);

	// sequencer branch
	always_comb begin
		unique case (uw.jmp) inside
			lbd_pkg::JMP_NEXT, lbd_pkg::JMP_WAIT: pc_next = pc_q + 1'b1;
			lbd_pkg::JMP_LAST: pc_next = is_last ? lbd_pkg::STEP_IDLE : uw.target;
			default: pc_next = lbd_pkg::STEP_IDLE;
		endcase
	end

	// order count clamp, kept as last order index
	always_comb begin
		if (num_orders_q < 2) begin
			last_d = lbd_pkg::IDX_W'(1);
		end else if (num_orders_q > LIMIT) begin
			last_d = LAST_MAX;
		end else begin
			last_d = lbd_pkg::IDX_W'(num_orders_q - 1'b1);
		end
	end

	// position clamp
	always_comb begin
		if (x_pos < lbd_pkg::X_MIN) begin
			x_cl = lbd_pkg::X_MIN;
		end else if (x_pos > lbd_pkg::X_MAX) begin
			x_cl = lbd_pkg::X_MAX;
		end else begin
			x_cl = x_pos;
		end
	end

	// shared multiplicand: x, or the coefficient of the current order
	always_comb begin
		case (uw.opa)
			lbd_pkg::OPA_C1: a_op = {1'b0, lbd_pkg::coef_c1(n_q)};
			lbd_pkg::OPA_C2: a_op = {2'b00, lbd_pkg::coef_c2(n_q)};
			default:         a_op = {x_q[lbd_pkg::X_W-1], x_q};
		endcase
	end

	// per-lane datapath
	always_comb begin
		for (int i = 0; i < NL; i++) begin
			case (uw.opb)
				lbd_pkg::OPB_T:  src_b[i] = t_q[i];
				lbd_pkg::OPB_V2: src_b[i] = v2_q[i];
				default:         src_b[i] = v1_q[i];
			endcase
			// low half unsigned, high half signed
			if (uw.hi) begin
				b_op[i] = {src_b[i][VW-1], src_b[i][VW-1:lbd_pkg::HALF_W]};
			end else begin
				b_op[i] = {1'b0, src_b[i][lbd_pkg::HALF_W-1:0]};
			end
			prod[i] = a_op * b_op[i];
			prod_ext[i] = AW'(prod[i]);
			if (uw.hi) begin
				prod_ext[i] = prod_ext[i] <<< lbd_pkg::HALF_W;
			end
			sum_x[i] = acc_q[i] + lbd_pkg::RND_X;
			sum_c[i] = acc_q[i] + lbd_pkg::RND_C;
			t_new[i] = VW'(sum_x[i] >>> lbd_pkg::SH_X) + addend[i];
			v_new[i] = VW'(sum_c[i] >>> lbd_pkg::SH_C);
		end
	end

	// P lane adds nothing, P' adds P_{n-1}, P'' adds 2*P'_{n-1}
	assign addend[lbd_pkg::LANE_P] = '0;
	assign addend[lbd_pkg::LANE_D] = v1_q[lbd_pkg::LANE_P];
	assign addend[lbd_pkg::LANE_S] = v1_q[lbd_pkg::LANE_D] <<< 1;

	// output rounding to Q.15
	always_comb begin
		for (int i = 0; i < NL; i++) begin
			src_o[i] = (uw.emit == lbd_pkg::EMIT_V2) ? v2_q[i] : v1_q[i];
			rnd_o[i] = (src_o[i] + lbd_pkg::RND_O) >>> lbd_pkg::SH_OUT;
		end
	end

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q         <= lbd_pkg::STEP_IDLE;
			n_q          <= '0;
			last_q       <= LAST_MAX;
			num_orders_q <= lbd_pkg::NUM_ORDERS_RST;
			res_valid_q  <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready
					&& paddr == lbd_pkg::REG_NUM_ORDERS) begin
				num_orders_q <= pwdata[lbd_pkg::CNT_W-1:0];
			end
			if (advance) begin
				pc_q <= pc_next;
				if (uw.init) begin
					n_q    <= '0;
					last_q <= last_d;
				end else if (uw.inc_n) begin
					n_q <= n_q + 1'b1;
				end
			end
			if (emit_fire) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath and output payload
	always_ff @(posedge clk) begin
		if (advance) begin
			if (uw.init) begin
				x_q <= x_cl;
				v2_q[lbd_pkg::LANE_P] <= lbd_pkg::ONE_Q24;
				v2_q[lbd_pkg::LANE_D] <= '0;
				v2_q[lbd_pkg::LANE_S] <= '0;
				v1_q[lbd_pkg::LANE_P] <= VW'(x_cl) <<< lbd_pkg::SH_P1;
				v1_q[lbd_pkg::LANE_D] <= lbd_pkg::ONE_Q24;
				v1_q[lbd_pkg::LANE_S] <= '0;
			end
			for (int i = 0; i < NL; i++) begin
				case (uw.acc)
					lbd_pkg::ACC_LOAD: acc_q[i] <= prod_ext[i];
					lbd_pkg::ACC_ADD:  acc_q[i] <= acc_q[i] + prod_ext[i];
					lbd_pkg::ACC_SUB:  acc_q[i] <= acc_q[i] - prod_ext[i];
					default:           acc_q[i] <= acc_q[i];
				endcase
				if (uw.wr_t) begin
					t_q[i] <= t_new[i];
				end
				if (uw.wr_v) begin
					v2_q[i] <= v1_q[i];
					v1_q[i] <= v_new[i];
				end
			end
		end
		if (emit_fire) begin
			order_q    <= n_q;
			pv_q       <= lbd_pkg::PV_W'(lbd_pkg::sat(rnd_o[lbd_pkg::LANE_P],
				lbd_pkg::PV_LIM));
			fd_q       <= lbd_pkg::FD_W'(lbd_pkg::sat(rnd_o[lbd_pkg::LANE_D],
				lbd_pkg::FD_LIM));
			sd_q       <= lbd_pkg::SD_W'(lbd_pkg::sat(rnd_o[lbd_pkg::LANE_S],
				lbd_pkg::SD_LIM));
			last_out_q <= is_last;
		end
	end

	assign res_valid    = res_valid_q;
	assign order_index  = order_q;
	assign poly_value   = pv_q;
	assign first_deriv  = fd_q;
	assign second_deriv = sd_q;
	assign last_order   = last_out_q;

	assign pready = 1'b1;
	assign prdata = (paddr == lbd_pkg::REG_NUM_ORDERS)
		? lbd_pkg::DATA_W'(num_orders_q) : '0;

	// a taken position starts the run at order 0
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		pos_acc |=> (pc_q == lbd_pkg::STEP_E0 && n_q == '0))
		else $error("run did not start at order 0");

	// the order counter stays within the run while busy
	a_order_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q != lbd_pkg::STEP_IDLE) |-> (n_q <= last_q))
		else $error("order counter past last order");

	// clamped order count is always legal
	a_last_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(last_q != '0 && last_q <= LAST_MAX))
		else $error("illegal order count");

	// the last result word returns the sequencer to idle
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && is_last) |=> (pc_q == lbd_pkg::STEP_IDLE))
		else $error("sequencer not idle after last word");

endmodule
